>>> rtl/gpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared widths, codes and controller/datapath interface types for the
// GFSR pentanomial word generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

   // default sizing, handed down as top level parameters
   localparam int MAX_LAG_DEFAULT   = 1024;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed field widths
   localparam int OPERATION_BITS  = 1;
   localparam int SEED_INDEX_BITS = 10;
   localparam int SEED_WORD_BITS  = 32;
   localparam int RSP_WORD_BITS   = 32;
   localparam int LONG_LAG_BITS   = 11;
   localparam int LAG_BITS        = 10;
   localparam int DEC_BITS        = 7;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 11;

   localparam int MAX_DECIMATION = 64;

   // register reset values
   localparam logic [LONG_LAG_BITS-1:0] LONG_LAG_RESET   = 11'd521;
   localparam logic [LAG_BITS-1:0]      SECOND_LAG_RESET = 10'd3;
   localparam logic [LAG_BITS-1:0]      THIRD_LAG_RESET  = 10'd2;
   localparam logic [LAG_BITS-1:0]      FOURTH_LAG_RESET = 10'd1;
   localparam logic [DEC_BITS-1:0]      DECIMATION_RESET = 7'd1;

   // operation codes
   localparam logic [OPERATION_BITS-1:0] OP_LOAD = 1'b0;
   localparam logic [OPERATION_BITS-1:0] OP_STEP = 1'b1;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LONG_LAG   = 3'd0,
      REG_SECOND_LAG = 3'd1,
      REG_THIRD_LAG  = 3'd2,
      REG_FOURTH_LAG = 3'd3,
      REG_DECIMATION = 3'd4
   } gpg_reg_type;

   // ring taps: oldest word and the three shorter lags
   typedef enum logic [1:0] {
      TAP_OLDEST = 2'd0,
      TAP_Q      = 2'd1,
      TAP_R      = 2'd2,
      TAP_S      = 2'd3
   } gpg_tap_type;

   typedef struct packed {
      logic        seed_wr;
      logic        mod_load;
      logic        mod_step;
      logic        mod_store;
      gpg_tap_type lag_sel;
      logic        step_start;
      logic        rd_en;
      gpg_tap_type rd_sel;
      logic        acc_load;
      logic        acc_xor;
      logic        word_wr;
      logic        out_load;
   } gpg_cmd_type;

   typedef struct packed {
      logic mod_done;
      logic last_word;
   } gpg_status_type;

endpackage
`default_nettype wire

>>> rtl/gfsr_pentanomial_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// A load word is written into the ring as it is accepted; a step word reads and
//   writes back d ring words, d being the clamped decimation, then raises rsp_valid.
// A new request is taken only once the step has loaded its response; each ring word
//   takes four tap reads, then the write-back, on the single ring read port.
// The first step after a lag register write first runs the lag reduction.
// Reset (synchronous, high): registers to defaults, pointer 0, no response, ring unseeded.
// ----------------------------------------------------------------------------
// gfsr_pentanomial_generator
// GFSR word generator, x_n = x_{n-p} ^ x_{n-q} ^ x_{n-r} ^ x_{n-s}, with
// decimation; seed words are loaded into a ring of p words.
// ----------------------------------------------------------------------------
module gfsr_pentanomial_generator #(
   parameter int MAX_LAG   = gpg_pkg::MAX_LAG_DEFAULT,
   parameter int WORD_BITS = gpg_pkg::WORD_BITS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   // request words: seed load or step
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [gpg_pkg::OPERATION_BITS-1:0]  req_operation,
   input  wire [gpg_pkg::SEED_INDEX_BITS-1:0] req_seed_index,
   input  wire [gpg_pkg::SEED_WORD_BITS-1:0]  req_seed_word,
   // response words
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [gpg_pkg::RSP_WORD_BITS-1:0]  rsp_random_word,
   // register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [gpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [gpg_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import gpg_pkg::*;

   gpg_cmd_type    cmd;
   gpg_status_type status;

   // registers are always writable; they are to change only while the block idles, which the user must ensure
   assign csr_ready = 1'b1;

   // Controller walks each word through its stages: read oldest tap, then
   // q, r and s taps (xor-accumulating the registered read data), then
   // write back.  Reduced lags (lag mod p) are cached and recomputed only
   // after reset or a lag register write, one lag at a time.
   gpg_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .cmd           (cmd),
      .status        (status)
   );

   // Datapath: ring memory (one write, one registered read per cycle),
   // pointer wrap modulo p, remainder unit and output register.
   gpg_datapath #(
      .MAX_LAG   (MAX_LAG),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_seed_index  (req_seed_index),
      .req_seed_word   (req_seed_word),
      .rsp_random_word (rsp_random_word)
   );

endmodule
`default_nettype wire

>>> rtl/gpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpg_datapath
// Config registers, lag reduction, word ring memory, tap addressing and
// output register.
// ----------------------------------------------------------------------------
module gpg_datapath #(
   parameter int MAX_LAG   = gpg_pkg::MAX_LAG_DEFAULT,
   parameter int WORD_BITS = gpg_pkg::WORD_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  gpg_pkg::gpg_cmd_type                  cmd,
   output gpg_pkg::gpg_status_type               status,
   input  wire                                   csr_valid,
   input  wire [gpg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire [gpg_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire [gpg_pkg::SEED_INDEX_BITS-1:0]    req_seed_index,
   input  wire [gpg_pkg::SEED_WORD_BITS-1:0]     req_seed_word,
   output logic [gpg_pkg::RSP_WORD_BITS-1:0]     rsp_random_word
);
   import gpg_pkg::*;

   localparam int AW  = $clog2(MAX_LAG);
   localparam int PW  = $clog2(MAX_LAG + 1);
   localparam int MCW = $clog2(LAG_BITS + 1);

   logic [LONG_LAG_BITS-1:0] long_lag_ff;
   logic [LAG_BITS-1:0]      second_lag_ff;
   logic [LAG_BITS-1:0]      third_lag_ff;
   logic [LAG_BITS-1:0]      fourth_lag_ff;
   logic [DEC_BITS-1:0]      decimation_ff;

   logic [PW-1:0]       p_eff;
   logic [DEC_BITS-1:0] dec_eff;

   logic [LAG_BITS-1:0] mod_lag;
   logic [LAG_BITS-1:0] mod_shift_ff;
   logic [AW-1:0]       mod_rem_ff;
   logic [AW-1:0]       mod_rem_in;
   logic [MCW-1:0]      mod_left_ff;
   logic [AW:0]         mod_trial;
   logic [AW:0]         p_wide;

   logic [AW-1:0] lag_q_ff;
   logic [AW-1:0] lag_r_ff;
   logic [AW-1:0] lag_s_ff;

   logic [AW-1:0]       ptr_ff;
   logic [AW-1:0]       ptr_in;
   logic [DEC_BITS-1:0] cnt_ff;

   logic [WORD_BITS-1:0] ring_mem [MAX_LAG];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WORD_BITS-1:0] acc_ff;
   logic [WORD_BITS-1:0] new_word;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic [WORD_BITS-1:0] wdata;
   logic                 wr_en;
   logic                 seed_in_range;

   logic [RSP_WORD_BITS-1:0] rsp_word_ff;

   // ring position lag places behind pos; both already below p
   function automatic logic [AW-1:0] behind(input logic [AW-1:0] pos,
                                            input logic [AW-1:0] lag,
                                            input logic [PW-1:0] p);
      logic [PW:0] wrapped;
      wrapped = (PW+1)'(pos) + (PW+1)'(p) - (PW+1)'(lag);
      if (pos >= lag) begin
         return pos - lag;
      end else begin
         return AW'(wrapped);
      end
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_lag_ff   <= LONG_LAG_RESET;
         second_lag_ff <= SECOND_LAG_RESET;
         third_lag_ff  <= THIRD_LAG_RESET;
         fourth_lag_ff <= FOURTH_LAG_RESET;
         decimation_ff <= DECIMATION_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LONG_LAG:   long_lag_ff   <= csr_wdata[LONG_LAG_BITS-1:0];
            REG_SECOND_LAG: second_lag_ff <= csr_wdata[LAG_BITS-1:0];
            REG_THIRD_LAG:  third_lag_ff  <= csr_wdata[LAG_BITS-1:0];
            REG_FOURTH_LAG: fourth_lag_ff <= csr_wdata[LAG_BITS-1:0];
            REG_DECIMATION: decimation_ff <= csr_wdata[DEC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp ring length and decimation
   always_comb begin
      if (long_lag_ff < LONG_LAG_BITS'(2)) begin
         p_eff = PW'(2);
      end else if (int'(long_lag_ff) > MAX_LAG) begin
         p_eff = PW'(MAX_LAG);
      end else begin
         p_eff = PW'(long_lag_ff);
      end
      if (decimation_ff == '0) begin
         dec_eff = DEC_BITS'(1);
      end else if (int'(decimation_ff) > MAX_DECIMATION) begin
         dec_eff = DEC_BITS'(MAX_DECIMATION);
      end else begin
         dec_eff = decimation_ff;
      end
   end

   // restoring remainder, one lag bit per cycle
   always_comb begin
      case (cmd.lag_sel)
         TAP_R:   mod_lag = third_lag_ff;
         TAP_S:   mod_lag = fourth_lag_ff;
         default: mod_lag = second_lag_ff;
      endcase
      p_wide    = (AW+1)'(p_eff);
      mod_trial = {mod_rem_ff, mod_shift_ff[LAG_BITS-1]};
      if (mod_trial >= p_wide) begin
         mod_rem_in = AW'(mod_trial - p_wide);
      end else begin
         mod_rem_in = AW'(mod_trial);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_left_ff <= '0;
      end else if (cmd.mod_load) begin
         mod_left_ff <= MCW'(LAG_BITS);
      end else if (cmd.mod_step && mod_left_ff != '0) begin
         mod_left_ff <= mod_left_ff - MCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_load) begin
         mod_shift_ff <= mod_lag;
         mod_rem_ff   <= '0;
      end else if (cmd.mod_step && mod_left_ff != '0) begin
         mod_shift_ff <= {mod_shift_ff[LAG_BITS-2:0], 1'b0};
         mod_rem_ff   <= mod_rem_in;
      end
      if (cmd.mod_store) begin
         case (cmd.lag_sel)
            TAP_R:   lag_r_ff <= mod_rem_ff;
            TAP_S:   lag_s_ff <= mod_rem_ff;
            default: lag_q_ff <= mod_rem_ff;
         endcase
      end
   end

   // ring pointer and word counter
   always_comb begin
      if (cmd.seed_wr) begin
         ptr_in = '0;
      end else if (cmd.step_start) begin
         ptr_in = (PW'(ptr_ff) >= p_eff) ? '0 : ptr_ff;
      end else if (cmd.word_wr) begin
         ptr_in = (PW'(ptr_ff) + PW'(1) == p_eff) ? '0 : ptr_ff + AW'(1);
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.step_start) begin
            cnt_ff <= dec_eff;
         end else if (cmd.word_wr) begin
            cnt_ff <= cnt_ff - DEC_BITS'(1);
         end
      end
   end

   // tap addressing and ring memory
   always_comb begin
      case (cmd.rd_sel)
         TAP_Q:   raddr = behind(ptr_ff, lag_q_ff, p_eff);
         TAP_R:   raddr = behind(ptr_ff, lag_r_ff, p_eff);
         TAP_S:   raddr = behind(ptr_ff, lag_s_ff, p_eff);
         default: raddr = ptr_ff;
      endcase
      new_word      = acc_ff ^ rd_data_ff;
      seed_in_range = int'(req_seed_index) < MAX_LAG;
      wr_en         = (cmd.seed_wr && seed_in_range) || cmd.word_wr;
      waddr         = cmd.word_wr ? ptr_ff : AW'(req_seed_index);
      wdata         = cmd.word_wr ? new_word : WORD_BITS'(req_seed_word);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         acc_ff <= rd_data_ff;
      end else if (cmd.acc_xor) begin
         acc_ff <= acc_ff ^ rd_data_ff;
      end
      if (cmd.out_load) begin
         rsp_word_ff <= RSP_WORD_BITS'(new_word);
      end
   end

   assign status.mod_done  = (mod_left_ff == '0);
   assign status.last_word = (cnt_ff == DEC_BITS'(1));
   assign rsp_random_word  = rsp_word_ff;

endmodule
`default_nettype wire

>>> rtl/gpg_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpg_controller
// Sequencer for seed loads, lag reduction and the per-word read/xor/write
// cycle; owns the request and response handshakes.
// ----------------------------------------------------------------------------
module gpg_controller (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire [gpg_pkg::OPERATION_BITS-1:0]  req_operation,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   input  wire                                csr_valid,
   input  wire [gpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   output gpg_pkg::gpg_cmd_type               cmd,
   input  gpg_pkg::gpg_status_type            status
);
   import gpg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_INIT,
      ST_MOD_RUN,
      ST_START,
      ST_RD_OLD,
      ST_RD_Q,
      ST_RD_R,
      ST_RD_S,
      ST_WRITE,
      ST_OUT
   } state_type;

   state_type   state_ff;
   gpg_tap_type lag_sel_ff;
   logic        lags_ok_ff;
   logic        rsp_valid_ff;
   logic        lag_write;
   logic        out_free;

   assign lag_write = csr_valid && (csr_index == REG_LONG_LAG ||
                                    csr_index == REG_SECOND_LAG ||
                                    csr_index == REG_THIRD_LAG ||
                                    csr_index == REG_FOURTH_LAG);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.lag_sel = lag_sel_ff;
      cmd.rd_sel  = TAP_OLDEST;
      case (state_ff)
         ST_IDLE:     cmd.seed_wr = req_valid && (req_operation == OP_LOAD);
         ST_MOD_INIT: cmd.mod_load = 1'b1;
         ST_MOD_RUN: begin
            cmd.mod_step  = 1'b1;
            cmd.mod_store = status.mod_done;
         end
         ST_START:    cmd.step_start = 1'b1;
         ST_RD_OLD:   cmd.rd_en = 1'b1;
         ST_RD_Q: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = TAP_Q;
            cmd.acc_load = 1'b1;
         end
         ST_RD_R: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = TAP_R;
            cmd.acc_xor = 1'b1;
         end
         ST_RD_S: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = TAP_S;
            cmd.acc_xor = 1'b1;
         end
         ST_WRITE:    cmd.word_wr = 1'b1;
         ST_OUT:      cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lag_sel_ff   <= TAP_Q;
         lags_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (lag_write) begin
            lags_ok_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_operation == OP_STEP) begin
                  lag_sel_ff <= TAP_Q;
                  state_ff   <= lags_ok_ff ? ST_START : ST_MOD_INIT;
               end
            end
            ST_MOD_INIT: state_ff <= ST_MOD_RUN;
            ST_MOD_RUN: begin
               if (status.mod_done) begin
                  if (lag_sel_ff == TAP_S) begin
                     lags_ok_ff <= 1'b1;
                     state_ff   <= ST_START;
                  end else begin
                     lag_sel_ff <= (lag_sel_ff == TAP_Q) ? TAP_R : TAP_S;
                     state_ff   <= ST_MOD_INIT;
                  end
               end
            end
            ST_START: state_ff <= ST_RD_OLD;
            ST_RD_OLD: state_ff <= ST_RD_Q;
            ST_RD_Q:   state_ff <= ST_RD_R;
            ST_RD_R:   state_ff <= ST_RD_S;
            ST_RD_S:   state_ff <= ST_WRITE;
            ST_WRITE:  state_ff <= status.last_word ? ST_OUT : ST_RD_OLD;
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/gpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpg_checker
// Port-level checks on the generator's handshakes and sequencing.
// ----------------------------------------------------------------------------
module gpg_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_ready,
   input wire [gpg_pkg::OPERATION_BITS-1:0]  req_operation,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [gpg_pkg::RSP_WORD_BITS-1:0]   rsp_random_word
);
   import gpg_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_word))
      else $error("response word changed while stalled");

   // a step occupies the block
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_STEP |=> !req_ready)
      else $error("request taken right after a step");

   // a load leaves the block ready for the next request
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_LOAD |=> req_ready)
      else $error("block busy after a seed load");

   // a response only appears at the end of a step
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised while idle");

endmodule

bind gfsr_pentanomial_generator gpg_checker u_gpg_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - GFSR pentanomial word generator testbench
// Seeds the word ring through the request channel, steps the generator under
// a range of lag and decimation settings and checks every returned word
// against an in-bench model of the ring. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
   import gpg_pkg::*;

   localparam int MAX_LAG        = MAX_LAG_DEFAULT;
   localparam int MIN_LAG        = 2;
   localparam int LONG_LAG_TOP   = (1 << LONG_LAG_BITS) - 1;
   localparam int DEC_TOP        = (1 << DEC_BITS) - 1;
   localparam int CSR_LAST_INDEX = (1 << CSR_INDEX_BITS) - 1;
   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_PCT       = 12;
   // a load is done once accepted; this is ample before a register write
   localparam int SETTLE_CYCLES  = 16;
   // covers the worst step: full decimation, plus the lag reduction after a lag write
   localparam int TAIL_CYCLES    = 400;
   // far above the longest correct spell without any handshake
   localparam int WATCHDOG_LIMIT = 3000;
   // request words in total, seed loads included
   localparam int ITEM_TARGET    = 1450;
   localparam int BIG_RING_PHASE = 4;
   localparam int REPORT_CAP     = 200;

   // -------------------------------------------------------------------------
   // Ring model: mirrors the registers, the ring and its pointer, and holds
   // the words that steps still owe.
   // -------------------------------------------------------------------------
   class gfsr_word_model;
      logic [LONG_LAG_BITS-1:0] long_lag;
      logic [LAG_BITS-1:0]      second_lag;
      logic [LAG_BITS-1:0]      third_lag;
      logic [LAG_BITS-1:0]      fourth_lag;
      logic [DEC_BITS-1:0]      decimation;
      logic [RSP_WORD_BITS-1:0] word_ring [MAX_LAG];
      int unsigned              ring_pointer;
      logic [RSP_WORD_BITS-1:0] owed_words [$];
      int unsigned              mismatch_count;

      function new();
         long_lag       = LONG_LAG_RESET;
         second_lag     = SECOND_LAG_RESET;
         third_lag      = THIRD_LAG_RESET;
         fourth_lag     = FOURTH_LAG_RESET;
         decimation     = DECIMATION_RESET;
         ring_pointer   = 0;
         mismatch_count = 0;
         foreach (word_ring[i]) word_ring[i] = '0;
      endfunction

      // long lag clamped into 2..MAX_LAG
      static function int unsigned ring_size(logic [LONG_LAG_BITS-1:0] lag_reg);
         int unsigned words;
         words = lag_reg;
         if (words < MIN_LAG) words = MIN_LAG;
         if (words > MAX_LAG) words = MAX_LAG;
         return words;
      endfunction

      // ring slot lag places behind pos
      function int unsigned tap(int unsigned pos, int unsigned lag, int unsigned words);
         return (pos + words - (lag % words)) % words;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index,
                              logic [CSR_DATA_BITS-1:0] data);
         case (gpg_reg_type'(index))
            REG_LONG_LAG:   long_lag   = data[LONG_LAG_BITS-1:0];
            REG_SECOND_LAG: second_lag = data[LAG_BITS-1:0];
            REG_THIRD_LAG:  third_lag  = data[LAG_BITS-1:0];
            REG_FOURTH_LAG: fourth_lag = data[LAG_BITS-1:0];
            REG_DECIMATION: decimation = data[DEC_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [OPERATION_BITS-1:0] op,
                                 logic [SEED_INDEX_BITS-1:0] index,
                                 logic [SEED_WORD_BITS-1:0] seed);
         int unsigned words, ptr, rounds, i;
         logic [RSP_WORD_BITS-1:0] w;
         if (op == OP_LOAD) begin
            if (index < MAX_LAG) word_ring[index] = seed;
            ring_pointer = 0;
         end else begin
            words  = ring_size(long_lag);
            ptr    = (ring_pointer >= words) ? 0 : ring_pointer;
            rounds = decimation;
            if (rounds < 1) rounds = 1;
            if (rounds > MAX_DECIMATION) rounds = MAX_DECIMATION;
            w = '0;
            for (i = 0; i < rounds; i++) begin
               w = word_ring[ptr]
                 ^ word_ring[tap(ptr, second_lag, words)]
                 ^ word_ring[tap(ptr, third_lag, words)]
                 ^ word_ring[tap(ptr, fourth_lag, words)];
               word_ring[ptr] = w;
               ptr = (ptr + 1) % words;
            end
            ring_pointer = ptr;
            owed_words.push_back(w);
         end
      endfunction

      task report_mismatch(string what, logic [RSP_WORD_BITS-1:0] got,
                           logic [RSP_WORD_BITS-1:0] want);
         mismatch_count++;
         if (mismatch_count <= REPORT_CAP)
            $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
      endtask

      task check_word(logic [RSP_WORD_BITS-1:0] got);
         logic [RSP_WORD_BITS-1:0] want;
         if (owed_words.size() == 0) begin
            report_mismatch("word with none owed", got, 'x);
         end else begin
            want = owed_words.pop_front();
            if (got !== want) report_mismatch("random_word", got, want);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block signals; those the bench drives are known from time zero
   // -------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OPERATION_BITS-1:0]  req_operation = OP_LOAD;
   logic [SEED_INDEX_BITS-1:0] req_seed_index = '0;
   logic [SEED_WORD_BITS-1:0]  req_seed_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [RSP_WORD_BITS-1:0]   rsp_random_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = REG_LONG_LAG;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   gfsr_word_model model;

   // which ring slots hold a seed; steps never read an unseeded slot
   bit                         seeded [MAX_LAG];
   // long lag as last programmed, kept by the driver itself
   logic [LONG_LAG_BITS-1:0]   cfg_long_lag = LONG_LAG_RESET;
   bit                         unused_reg_hit = 1'b0;
   int unsigned                idle_pct = IDLE_PCT;
   int unsigned                sent_items = 0;

   gfsr_pentanomial_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_seed_index  (req_seed_index),
      .req_seed_word   (req_seed_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Monitors. Everything is sampled at the rising edge, before the nonblocking
   // updates of that edge land, so the order of processes does not matter.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         model.note_request(req_operation, req_seed_index, req_seed_word);
      if (!reset && csr_valid && csr_ready)
         model.write_reg(csr_index, csr_wdata);
   end

   // result side: random back-pressure, check each accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) model.check_word(rsp_random_word);
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run once no word has moved on any channel for too long
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   function automatic bit idle_now();
      return $urandom_range(0, 99) < idle_pct;
   endfunction

   // One request word. Valid only drops when an idle gap is rolled, so a
   // back-to-back word keeps valid high across the edge.
   task automatic send_request(logic [OPERATION_BITS-1:0] op,
                               logic [SEED_INDEX_BITS-1:0] index,
                               logic [SEED_WORD_BITS-1:0] seed);
      if (idle_now()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_seed_index <= index;
      req_seed_word  <= seed;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) seeded[index] = 1'b1;
      sent_items++;
   endtask

   // step words carry junk in the seed fields; the block must ignore it
   task automatic send_step();
      send_request(OP_STEP, SEED_INDEX_BITS'($urandom), $urandom);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index,
                            logic [CSR_DATA_BITS-1:0] data);
      if (idle_now()) begin
         csr_valid <= 1'b0;
         do @(posedge clock); while (idle_now());
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Wait until every owed word is back, then let any trailing load finish.
   // The first edge is taken before looking so that a step accepted at the
   // current edge has already been noted.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (model.owed_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program all five registers while idle. Unused upper data bits are
   // randomised, since the block keeps only the register width. Now and then
   // a write to an index with no register goes in as well.
   task automatic write_config(logic [LONG_LAG_BITS-1:0] p, logic [LAG_BITS-1:0] q,
                               logic [LAG_BITS-1:0] r, logic [LAG_BITS-1:0] s,
                               logic [DEC_BITS-1:0] d);
      logic [CSR_DATA_BITS-1:0] junk;
      drain();
      junk = CSR_DATA_BITS'($urandom);
      if (!unused_reg_hit || $urandom_range(0, 7) == 0) begin
         write_csr(CSR_INDEX_BITS'($urandom_range(REG_DECIMATION + 1, CSR_LAST_INDEX)),
                   CSR_DATA_BITS'($urandom));
         unused_reg_hit = 1'b1;
      end
      write_csr(REG_LONG_LAG, p);
      write_csr(REG_SECOND_LAG, {junk[CSR_DATA_BITS-1:LAG_BITS], q});
      write_csr(REG_THIRD_LAG, {junk[CSR_DATA_BITS-1:LAG_BITS], r});
      write_csr(REG_FOURTH_LAG, {~junk[CSR_DATA_BITS-1:LAG_BITS], s});
      write_csr(REG_DECIMATION, {junk[CSR_DATA_BITS-1:DEC_BITS], d});
      csr_valid    <= 1'b0;
      cfg_long_lag  = p;
   endtask

   // load any slot of the active ring that has never held a seed
   task automatic seed_missing();
      int unsigned words, i;
      words = gfsr_word_model::ring_size(cfg_long_lag);
      for (i = 0; i < words; i++)
         if (!seeded[i]) send_request(OP_LOAD, SEED_INDEX_BITS'(i), $urandom);
   endtask

   function automatic logic [LAG_BITS-1:0] extreme_lag();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return LAG_BITS'(1);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [LONG_LAG_BITS-1:0] ll;
      logic [LAG_BITS-1:0]      q, r, s;
      logic [DEC_BITS-1:0]      dec;
      int unsigned              words, n_items, phase, k;

      model = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // small ordered ring, seed extremes, top seed index outside the ring
      write_config(11'd4, 10'd3, 10'd2, 10'd1, 7'd1);
      send_request(OP_LOAD, 10'd0, 32'h0000_0000);
      send_request(OP_LOAD, 10'd1, 32'hFFFF_FFFF);
      send_request(OP_LOAD, 10'd2, 32'hA5A5_A5A5);
      send_request(OP_LOAD, 10'd3, 32'h5A5A_5A5A);
      send_request(OP_LOAD, '1, 32'hFFFF_FFFF);
      repeat (3) send_step();
      // long lag below 2, second lag past the ring, a zero lag, decimation 0
      write_config(11'd0, 10'd5, 10'd0, '1, 7'd0);
      repeat (2) send_step();
      // unordered lags, decimation above the cap; a load resets the pointer
      write_config(11'd3, 10'd1, 10'd1, 10'd2, 7'(DEC_TOP));
      send_step();
      send_request(OP_LOAD, 10'd2, 32'h8000_0001);
      send_step();
      // walk the pointer well into a ring of 8, then shrink the ring under it
      write_config(11'd8, 10'd5, 10'd3, 10'd1, 7'd1);
      seed_missing();
      repeat (6) send_step();
      write_config(11'd4, 10'd3, 10'd2, 10'd1, 7'd2);
      send_step();

      // --- random phases ---
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         phase++;
         // a run of phases with no idling on either side
         idle_pct = (phase >= 5 && phase < 9) ? 0 : IDLE_PCT;

         // ring length: mostly small; one phase seeds the full store, after
         // which the big and clamped settings come round at random
         if (phase == BIG_RING_PHASE) begin
            ll = LONG_LAG_BITS'($urandom_range(MAX_LAG, LONG_LAG_TOP));
         end else begin
            case ($urandom_range(0, 9))
               0:       ll = LONG_LAG_BITS'($urandom_range(0, MIN_LAG - 1));
               1:       ll = (phase > BIG_RING_PHASE) ?
                             LONG_LAG_BITS'($urandom_range(MAX_LAG, LONG_LAG_TOP)) :
                             LONG_LAG_BITS'(MIN_LAG);
               2:       ll = (phase > BIG_RING_PHASE) ?
                             LONG_LAG_BITS'($urandom_range(33, 300)) :
                             LONG_LAG_BITS'($urandom_range(17, 48));
               default: ll = LONG_LAG_BITS'($urandom_range(MIN_LAG, 32));
            endcase
         end
         words = gfsr_word_model::ring_size(ll);

         // lags: in half the draws a proper q > r > s below p where p allows, otherwise anything goes
         case ($urandom_range(0, 5))
            0: begin
               q = LAG_BITS'($urandom);
               r = LAG_BITS'($urandom);
               s = LAG_BITS'($urandom);
            end
            1: begin
               q = extreme_lag();
               r = extreme_lag();
               s = extreme_lag();
            end
            2: begin
               q = LAG_BITS'($urandom_range(0, words - 1));
               r = LAG_BITS'($urandom_range(0, words - 1));
               s = LAG_BITS'($urandom_range(0, words - 1));
            end
            default: begin
               if (words >= 4) begin
                  q = LAG_BITS'($urandom_range(3, words - 1));
                  r = LAG_BITS'($urandom_range(2, q - 1));
                  s = LAG_BITS'($urandom_range(1, r - 1));
               end else begin
                  q = LAG_BITS'($urandom_range(0, words - 1));
                  r = LAG_BITS'($urandom_range(0, words - 1));
                  s = LAG_BITS'($urandom_range(0, words - 1));
               end
            end
         endcase

         case ($urandom_range(0, 7))
            0:       dec = '0;
            1:       dec = DEC_BITS'($urandom_range(MAX_DECIMATION + 1, DEC_TOP));
            2:       dec = DEC_BITS'(MAX_DECIMATION);
            3:       dec = DEC_BITS'($urandom_range(9, MAX_DECIMATION - 1));
            default: dec = DEC_BITS'($urandom_range(1, 8));
         endcase

         write_config(ll, q, r, s, dec);
         seed_missing();

         // mostly steps; stray loads anywhere in the store reset the pointer
         n_items = $urandom_range(15, 60);
         for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 80)
               send_step();
            else
               send_request(OP_LOAD, SEED_INDEX_BITS'($urandom), $urandom);
         end
      end

      // --- wind down ---
      req_valid <= 1'b0;
      do @(posedge clock); while (model.owed_words.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (model.mismatch_count == 0 && model.owed_words.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/gpg_pkg.sv
rtl/gpg_datapath.sv
rtl/gpg_controller.sv
rtl/gfsr_pentanomial_generator.sv
rtl/gpg_checker.sv
tb/sv/tb.sv
